@@ design/htfd_pkg.sv @@
// Shared constants, types and helper functions of the humidity/temperature frame decoder.
`default_nettype none

package htfd_pkg;

   localparam int unsigned DATA_W     = 8;
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned VAL_W      = 18;
   localparam int unsigned GAIN_W     = 18;
   localparam int unsigned OFFS_W     = 16;
   localparam int unsigned SCALE_W    = 2;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned POS_W      = 3;
   localparam int unsigned FRAME_LEN  = 5;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 18;
   localparam int unsigned MUL_W      = 25;
   localparam int unsigned PROD_W     = 2 * MUL_W;
   localparam int unsigned WIDE_W     = 36;
   localparam int unsigned CAL_SHIFT  = 16;
   localparam int unsigned DIV5_SHIFT = 25;
   localparam int unsigned FBIAS_W    = 23;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CRC     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TEMP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_OFFSET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HUM_OFFSET  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_SCALE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_MODE    = 3'd5;

   localparam logic [SCALE_W-1:0] SCALE_CELSIUS    = 2'd0;
   localparam logic [SCALE_W-1:0] SCALE_KELVIN     = 2'd1;
   localparam logic [SCALE_W-1:0] SCALE_FAHRENHEIT = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 18'd65536;

   localparam logic [DATA_W-1:0] CRC_POLY = 8'h31;
   localparam logic [DATA_W-1:0] CRC_INIT = 8'hFF;

   localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
   localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
   localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
   localparam logic [POS_W-1:0] POS_LAST  = 3'd5;

   // full-scale spans in Q8: 175*256 and 100*256
   localparam logic signed [MUL_W-1:0] TEMP_SPAN  = 25'sd44800;
   localparam logic signed [MUL_W-1:0] HUM_SPAN   = 25'sd25600;
   // ceil(2^25 / 5)
   localparam logic signed [MUL_W-1:0] DIV5_RECIP = 25'sd6710887;

   localparam logic signed [VAL_W-1:0]  CEL_OFFSET  = 18'sd11520;
   localparam logic signed [WIDE_W-1:0] KELVIN_Q8   = 36'sd69926;
   localparam logic signed [WIDE_W-1:0] FAHR_OFFSET = 36'sd8192;
   // keeps 9*celsius positive before the divide by five: 5 * DIV5_BIAS_K
   localparam logic signed [WIDE_W-1:0] DIV5_BIAS_K = 36'sd262144;
   localparam logic signed [WIDE_W-1:0] DIV5_BIAS   = 36'sd1310720;

   localparam logic signed [WIDE_W-1:0] SAT_MAX = 36'sd131071;
   localparam logic signed [WIDE_W-1:0] SAT_MIN = -36'sd131072;

   typedef struct packed {
      logic last_byte;
      logic crc_good;
   } frame_status_type;

   // one CRC byte step, message byte already folded into the seed
   function automatic logic [DATA_W-1:0] crc8_byte(input logic [DATA_W-1:0] seed);
      logic [DATA_W-1:0] c;
      c = seed;
      for (int k = 0; k < DATA_W; k++) begin
         c = c[DATA_W-1] ? ({c[DATA_W-2:0], 1'b0} ^ CRC_POLY) : {c[DATA_W-2:0], 1'b0};
      end
      return c;
   endfunction

   // floor(x / 65535): x>>16 undershoots by at most one for the products used here
   function automatic logic [WORD_W-1:0] div65535(input logic [2*WORD_W-1:0] x);
      logic [WORD_W-1:0] q0;
      logic [WORD_W:0]   r;
      q0 = x[2*WORD_W-1:WORD_W];
      r  = {1'b0, x[WORD_W-1:0]} + {1'b0, q0};
      return (r >= 17'd65535) ? q0 + 16'd1 : q0;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat18(input logic signed [WIDE_W-1:0] v);
      logic signed [VAL_W-1:0] res;
      if (v > SAT_MAX) begin
         res = VAL_W'(SAT_MAX);
      end else if (v < SAT_MIN) begin
         res = VAL_W'(SAT_MIN);
      end else begin
         res = VAL_W'(v);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ design/htfd_if.sv @@
// Valid/ready channel interfaces: sensor byte input, result output and register writes.
`default_nettype none

interface htfd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [htfd_pkg::DATA_W-1:0]   data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface htfd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [htfd_pkg::VAL_W-1:0]    temperature;
   logic signed [htfd_pkg::VAL_W-1:0]    humidity;
   logic [htfd_pkg::STATUS_W-1:0]        status;

   modport source (output valid, output temperature, output humidity, output status,
                   input ready);
   modport sink   (input valid, input temperature, input humidity, input status,
                   output ready);
endinterface

interface htfd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [htfd_pkg::CSR_IDX_W-1:0]    index;
   logic [htfd_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ design/htfd_frame.sv @@
// Frame collector: byte position, stored frame bytes and running CRC-8 of both words.
`default_nettype none

module htfd_frame (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          byte_accept,
   input  wire logic                          abort,
   input  wire logic [htfd_pkg::DATA_W-1:0]   data_byte,
   output      htfd_pkg::frame_status_type    status,
   output      logic [htfd_pkg::WORD_W-1:0]   temp_raw,
   output      logic [htfd_pkg::WORD_W-1:0]   hum_raw
);
   import htfd_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] store_ff [FRAME_LEN];
   logic [DATA_W-1:0] crc_t_ff, crc_t_in;
   logic [DATA_W-1:0] crc_h_ff, crc_h_in;
   logic [DATA_W-1:0] crc_seed;
   logic [DATA_W-1:0] crc_next;

   always_comb begin
      if (pos_ff == POS_T_HI || pos_ff == POS_H_HI) begin
         crc_seed = CRC_INIT;
      end else if (pos_ff == POS_T_LO) begin
         crc_seed = crc_t_ff;
      end else begin
         crc_seed = crc_h_ff;
      end
      crc_next = crc8_byte(crc_seed ^ data_byte);
   end

   always_comb begin
      pos_in   = pos_ff;
      crc_t_in = crc_t_ff;
      crc_h_in = crc_h_ff;
      if (abort) begin
         pos_in = '0;
      end else if (byte_accept) begin
         pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + 3'd1;
         if (pos_ff == POS_T_HI || pos_ff == POS_T_LO) begin
            crc_t_in = crc_next;
         end
         if (pos_ff == POS_H_HI || pos_ff == POS_LAST - 3'd1) begin
            crc_h_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_t_ff <= crc_t_in;
      crc_h_ff <= crc_h_in;
      if (byte_accept && pos_ff < POS_LAST) begin
         store_ff[pos_ff] <= data_byte;
      end
   end

   // the sixth byte is the humidity CRC, checked as it arrives
   assign status.last_byte = byte_accept && (pos_ff == POS_LAST);
   assign status.crc_good  = (crc_t_ff == store_ff[2]) && (crc_h_ff == data_byte);

   assign temp_raw = {store_ff[0], store_ff[1]};
   assign hum_raw  = {store_ff[3], store_ff[4]};

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("frame position beyond last byte");

   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      (status.last_byte || abort) |=> pos_ff == '0)
      else $error("frame position not restarted after end of frame");

endmodule

`default_nettype wire

@@ design/htfd_mul.sv @@
// Shared signed multiplier with registered product, used for the span, gain and divide-by-five products.
`default_nettype none

module htfd_mul (
   input  wire logic                                clock,
   input  wire logic                                enable,
   input  wire logic signed [htfd_pkg::MUL_W-1:0]   op_a,
   input  wire logic signed [htfd_pkg::MUL_W-1:0]   op_b,
   output      logic signed [htfd_pkg::PROD_W-1:0]  prod
);
   import htfd_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

@@ design/humidity_temp_frame_decoder.sv @@
// Top level: frame decoder with register file, conversion sequencer and result register.
//
//  Channel  Dir  Payload                              Transaction
//  req      in   op, data_byte                        one sensor byte or a timeout
//  rsp      out  temperature, humidity, status        one result per frame end or abort
//  csr      in   index, wdata                         one register write, always ready
//
// Bytes one to five take one cycle each and give no result.
// Sixth byte: TMUL, TDIV, TGAIN, TCAL, HMUL, HDIV, HGAIN, HCAL, UNIT, FDIV in Fahrenheit,
// then DONE; span, gain and divide-by-five products share the one 25x25 multiplier, at
// most one multiply per state. Timeout or CRC error: zero values go straight to DONE, last
// good values join at UNIT. req ready is low while the sequencer runs; a finished result
// waits in the output register, and only the next result stalls until it is taken.
// Synchronous reset restores register defaults, clears the frame position and last values.
`default_nettype none

module humidity_temp_frame_decoder (
   input wire logic   clock,
   input wire logic   reset,
   htfd_req_if.sink   req_chan,
   htfd_rsp_if.source rsp_chan,
   htfd_csr_if.sink   csr_chan
);
   import htfd_pkg::*;

   localparam int unsigned ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] ST_TMUL  = 4'd1;
   localparam logic [ST_W-1:0] ST_TDIV  = 4'd2;
   localparam logic [ST_W-1:0] ST_TGAIN = 4'd3;
   localparam logic [ST_W-1:0] ST_TCAL  = 4'd4;
   localparam logic [ST_W-1:0] ST_HMUL  = 4'd5;
   localparam logic [ST_W-1:0] ST_HDIV  = 4'd6;
   localparam logic [ST_W-1:0] ST_HGAIN = 4'd7;
   localparam logic [ST_W-1:0] ST_HCAL  = 4'd8;
   localparam logic [ST_W-1:0] ST_UNIT  = 4'd9;
   localparam logic [ST_W-1:0] ST_FDIV  = 4'd10;
   localparam logic [ST_W-1:0] ST_DONE  = 4'd11;

   // configuration registers
   logic [GAIN_W-1:0]        temp_gain_ff;
   logic signed [OFFS_W-1:0] temp_offset_ff;
   logic [GAIN_W-1:0]        hum_gain_ff;
   logic signed [OFFS_W-1:0] hum_offset_ff;
   logic [SCALE_W-1:0]       temp_scale_ff;
   logic                     err_mode_ff;

   // sequencer and datapath
   logic [ST_W-1:0]          state_ff, state_in;
   logic signed [VAL_W-1:0]  tcel_ff, tcel_in;
   logic signed [VAL_W-1:0]  hum_ff, hum_in;
   logic signed [VAL_W-1:0]  temp_res_ff, temp_res_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [VAL_W-1:0]  last_temp_ff, last_temp_in;
   logic signed [VAL_W-1:0]  last_hum_ff, last_hum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]  rsp_temp_ff;
   logic signed [VAL_W-1:0]  rsp_hum_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic                     rsp_load;

   logic                     req_accept;
   frame_status_type         frame_status;
   logic [WORD_W-1:0]        temp_raw;
   logic [WORD_W-1:0]        hum_raw;

   logic                     mul_en;
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod;

   logic [WORD_W-1:0]        quot;
   logic signed [VAL_W-1:0]  quot_val;
   logic signed [OFFS_W-1:0] cal_offset;
   logic signed [WIDE_W-1:0] cal_sum;
   logic signed [VAL_W-1:0]  cal_sat;
   logic signed [VAL_W-1:0]  kelvin_sat;
   logic signed [WIDE_W-1:0] fbias_wide;
   logic [FBIAS_W-1:0]       fbias;
   logic signed [WIDE_W-1:0] fahr_sum;
   logic signed [VAL_W-1:0]  fahr_sat;

   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   htfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_accept && !req_chan.op),
      .abort       (req_accept && req_chan.op),
      .data_byte   (req_chan.data_byte),
      .status      (frame_status),
      .temp_raw    (temp_raw),
      .hum_raw     (hum_raw)
   );

   htfd_mul u_mul (
      .clock  (clock),
      .enable (mul_en),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .prod   (prod)
   );

   // operand selection for the shared multiplier
   always_comb begin
      mul_en = 1'b1;
      unique case (state_ff)
         ST_TMUL: begin
            mul_a = MUL_W'(temp_raw);
            mul_b = TEMP_SPAN;
         end
         ST_TGAIN: begin
            mul_a = MUL_W'(tcel_ff);
            mul_b = MUL_W'(temp_gain_ff);
         end
         ST_HMUL: begin
            mul_a = MUL_W'(hum_raw);
            mul_b = HUM_SPAN;
         end
         ST_HGAIN: begin
            mul_a = MUL_W'(hum_ff);
            mul_b = MUL_W'(hum_gain_ff);
         end
         ST_UNIT: begin
            mul_a = MUL_W'(fbias);
            mul_b = DIV5_RECIP;
         end
         default: begin
            mul_en = 1'b0;
            mul_a  = '0;
            mul_b  = '0;
         end
      endcase
   end

   // post-multiply arithmetic on the registered product, and the Kelvin and Fahrenheit terms from tcel_ff
   always_comb begin
      quot       = div65535(prod[2*WORD_W-1:0]);
      quot_val   = VAL_W'(quot);
      cal_offset = (state_ff == ST_HCAL) ? hum_offset_ff : temp_offset_ff;
      cal_sum    = WIDE_W'(signed'(prod[PROD_W-1:CAL_SHIFT])) + WIDE_W'(cal_offset);
      cal_sat    = sat18(cal_sum);
      kelvin_sat = sat18(WIDE_W'(tcel_ff) + KELVIN_Q8);
      // 9*celsius shifted positive, floor-divided by five in the multiplier
      fbias_wide = (WIDE_W'(tcel_ff) <<< 3) + WIDE_W'(tcel_ff) + DIV5_BIAS;
      fbias      = fbias_wide[FBIAS_W-1:0];
      fahr_sum   = WIDE_W'(prod[PROD_W-1:DIV5_SHIFT]) - DIV5_BIAS_K + FAHR_OFFSET;
      fahr_sat   = sat18(fahr_sum);
   end

   always_comb begin
      state_in     = state_ff;
      tcel_in      = tcel_ff;
      hum_in       = hum_ff;
      temp_res_in  = temp_res_ff;
      status_in    = status_ff;
      last_temp_in = last_temp_ff;
      last_hum_in  = last_hum_ff;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_chan.op || frame_status.last_byte)) begin
               if (!req_chan.op && frame_status.crc_good) begin
                  status_in = STATUS_OK;
                  state_in  = ST_TMUL;
               end else begin
                  status_in = req_chan.op ? STATUS_TIMEOUT : STATUS_CRC;
                  if (err_mode_ff) begin
                     tcel_in  = last_temp_ff;
                     hum_in   = last_hum_ff;
                     state_in = ST_UNIT;
                  end else begin
                     temp_res_in = '0;
                     hum_in      = '0;
                     state_in    = ST_DONE;
                  end
               end
            end
         end
         ST_TMUL: begin
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            tcel_in  = quot_val - CEL_OFFSET;
            state_in = ST_TGAIN;
         end
         ST_TGAIN: begin
            state_in = ST_TCAL;
         end
         ST_TCAL: begin
            tcel_in  = cal_sat;
            state_in = ST_HMUL;
         end
         ST_HMUL: begin
            state_in = ST_HDIV;
         end
         ST_HDIV: begin
            hum_in   = quot_val;
            state_in = ST_HGAIN;
         end
         ST_HGAIN: begin
            state_in = ST_HCAL;
         end
         ST_HCAL: begin
            hum_in       = cal_sat;
            last_temp_in = tcel_ff;
            last_hum_in  = cal_sat;
            state_in     = ST_UNIT;
         end
         ST_UNIT: begin
            case (temp_scale_ff)
               SCALE_KELVIN: begin
                  temp_res_in = kelvin_sat;
                  state_in    = ST_DONE;
               end
               SCALE_FAHRENHEIT: begin
                  state_in = ST_FDIV;
               end
               default: begin
                  temp_res_in = tcel_ff;
                  state_in    = ST_DONE;
               end
            endcase
         end
         ST_FDIV: begin
            temp_res_in = fahr_sat;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         last_temp_ff   <= '0;
         last_hum_ff    <= '0;
         temp_gain_ff   <= GAIN_UNITY;
         temp_offset_ff <= '0;
         hum_gain_ff    <= GAIN_UNITY;
         hum_offset_ff  <= '0;
         temp_scale_ff  <= SCALE_CELSIUS;
         err_mode_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_temp_ff <= last_temp_in;
         last_hum_ff  <= last_hum_in;
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_chan.index)
               REG_TEMP_GAIN:   temp_gain_ff   <= csr_chan.wdata[GAIN_W-1:0];
               REG_TEMP_OFFSET: temp_offset_ff <= signed'(csr_chan.wdata[OFFS_W-1:0]);
               REG_HUM_GAIN:    hum_gain_ff    <= csr_chan.wdata[GAIN_W-1:0];
               REG_HUM_OFFSET:  hum_offset_ff  <= signed'(csr_chan.wdata[OFFS_W-1:0]);
               REG_TEMP_SCALE:  temp_scale_ff  <= csr_chan.wdata[SCALE_W-1:0];
               REG_ERR_MODE:    err_mode_ff    <= csr_chan.wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tcel_ff     <= tcel_in;
      hum_ff      <= hum_in;
      temp_res_ff <= temp_res_in;
      status_ff   <= status_in;
      if (rsp_load) begin
         rsp_temp_ff   <= temp_res_ff;
         rsp_hum_ff    <= hum_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.temperature = rsp_temp_ff;
   assign rsp_chan.humidity    = rsp_hum_ff;
   assign rsp_chan.status      = rsp_status_ff;

   a_timeout_path: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.op) |=> (state_ff == ST_DONE || state_ff == ST_UNIT))
      else $error("timeout transaction did not take the error path");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status_ff != STATUS_OK && !err_mode_ff)
      |-> (temp_res_ff == '0 && hum_ff == '0))
      else $error("error result carries non-zero values in zero mode");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the completion state");

endmodule

`default_nettype wire
